// ===== rtl/ial_pkg.sv =====
// Shared types and constants for the indexed array list core.
package ial_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int WORD_W       = 32;
    localparam int POS_W        = 4;
    localparam int LEN_FIELD_W  = 5;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef struct packed {
        action_t                   action;
        logic [POS_W-1:0]          position;
        logic signed [WORD_W-1:0]  value;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]  read_value;
        logic signed [WORD_W-1:0]  last_value;
        logic [LEN_FIELD_W-1:0]    length;
        status_t                   status;
    } rsp_t;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_FROM_LOWER = 2'd2,
        CELL_FROM_UPPER = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     rd_hit;
        logic     last_hit;
    } cell_ctrl_t;

endpackage

// ===== rtl/ial_cell.sv =====
// One list entry: holds a word, shifts with its neighbors, taps for read and last.
module ial_cell
(
    input  logic                              clk,
    input  ial_pkg::cell_ctrl_t               ctrl,
    input  logic signed [ial_pkg::WORD_W-1:0] value,
    input  logic signed [ial_pkg::WORD_W-1:0] lower_data,
    input  logic signed [ial_pkg::WORD_W-1:0] upper_data,
    output logic signed [ial_pkg::WORD_W-1:0] data,
    output logic signed [ial_pkg::WORD_W-1:0] rd_tap,
    output logic signed [ial_pkg::WORD_W-1:0] last_tap
);

    logic signed [ial_pkg::WORD_W-1:0] data_reg;
    logic signed [ial_pkg::WORD_W-1:0] data_next;

    always_comb
    begin
        case (ctrl.op)
            ial_pkg::CELL_LOAD:       data_next = value;
            ial_pkg::CELL_FROM_LOWER: data_next = lower_data;
            ial_pkg::CELL_FROM_UPPER: data_next = upper_data;
            default:                  data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    assign rd_tap   = ctrl.rd_hit   ? data_reg  : '0;
    assign last_tap = ctrl.last_hit ? data_next : '0;

endmodule

// ===== rtl/indexed_array_list_core.sv =====
// Top level of the indexed array list: control, row of entry cells, result register.
// Latency: a response is valid the cycle after its request transaction is accepted.
// Throughput: one transaction per cycle unless stalled; insert/remove shift the list tail.
// A new request is taken while the response register is empty or being drained.
// Reset (rst_n low, asynchronous) clears the list length and the response valid.
// Entry words are not reset; only entries below the length are ever read.
module indexed_array_list_core
#(
    parameter int CAPACITY = ial_pkg::CAPACITY_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ial_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ial_pkg::rsp_t rsp
);

    localparam int LEN_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((LEN_W > ial_pkg::POS_W) ? LEN_W : ial_pkg::POS_W) + 1;

    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    ial_pkg::rsp_t     rsp_reg;
    ial_pkg::rsp_t     rsp_next;

    logic              accept;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  len_ext;
    logic [CMP_W-1:0]  len_next_ext;
    logic              in_range;
    logic              full;
    ial_pkg::status_t  status;
    logic              do_append;
    logic              do_insert;
    logic              do_remove;
    logic signed [ial_pkg::WORD_W-1:0] rd_or;
    logic signed [ial_pkg::WORD_W-1:0] last_or;

    ial_pkg::cell_ctrl_t               ctrl  [CAPACITY];
    logic signed [ial_pkg::WORD_W-1:0] cdata [CAPACITY];
    logic signed [ial_pkg::WORD_W-1:0] rtap  [CAPACITY];
    logic signed [ial_pkg::WORD_W-1:0] ltap  [CAPACITY];

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;

    assign pos_ext  = CMP_W'(req.position);
    assign len_ext  = CMP_W'(len_reg);
    assign in_range = pos_ext < len_ext;
    assign full     = len_reg == LEN_W'(CAPACITY);

    always_comb
    begin
        status    = ial_pkg::ST_OK;
        do_append = 1'b0;
        do_insert = 1'b0;
        do_remove = 1'b0;
        case (req.action)
            ial_pkg::ACT_APPEND:
            begin
                if (full)
                    status = ial_pkg::ST_FULL;
                else
                    do_append = 1'b1;
            end
            ial_pkg::ACT_INSERT:
            begin
                if (!in_range)
                    status = ial_pkg::ST_BAD_INDEX;
                else if (full)
                    status = ial_pkg::ST_FULL;
                else
                    do_insert = 1'b1;
            end
            ial_pkg::ACT_REMOVE:
            begin
                if (!in_range)
                    status = ial_pkg::ST_BAD_INDEX;
                else
                    do_remove = 1'b1;
            end
            default:
            begin
                if (!in_range)
                    status = ial_pkg::ST_BAD_INDEX;
            end
        endcase
    end

    always_comb
    begin
        len_next = len_reg;
        if (accept && (do_append || do_insert))
            len_next = len_reg + LEN_W'(1);
        else if (accept && do_remove)
            len_next = len_reg - LEN_W'(1);
    end

    assign len_next_ext = CMP_W'(len_next);

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            localparam logic [CMP_W-1:0] IDX = CMP_W'(gi);
            logic signed [ial_pkg::WORD_W-1:0] lower_data;
            logic signed [ial_pkg::WORD_W-1:0] upper_data;

            always_comb
            begin
                ctrl[gi].op       = ial_pkg::CELL_HOLD;
                ctrl[gi].rd_hit   = IDX == pos_ext;
                ctrl[gi].last_hit = (len_next_ext != '0) &&
                                    (IDX == len_next_ext - CMP_W'(1));
                if (accept && do_append)
                begin
                    if (IDX == len_ext)
                        ctrl[gi].op = ial_pkg::CELL_LOAD;
                end
                else if (accept && do_insert)
                begin
                    if (IDX == pos_ext)
                        ctrl[gi].op = ial_pkg::CELL_LOAD;
                    else if (IDX > pos_ext && IDX <= len_ext)
                        ctrl[gi].op = ial_pkg::CELL_FROM_LOWER;
                end
                else if (accept && do_remove)
                begin
                    if (IDX >= pos_ext && (IDX + CMP_W'(1)) < len_ext)
                        ctrl[gi].op = ial_pkg::CELL_FROM_UPPER;
                end
            end

            if (gi == 0)
            begin : g_first
                assign lower_data = req.value;
            end
            else
            begin : g_mid_lo
                assign lower_data = cdata[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign upper_data = '0;
            end
            else
            begin : g_mid_hi
                assign upper_data = cdata[gi+1];
            end

            ial_cell u_cell
            (
                .clk        (clk),
                .ctrl       (ctrl[gi]),
                .value      (req.value),
                .lower_data (lower_data),
                .upper_data (upper_data),
                .data       (cdata[gi]),
                .rd_tap     (rtap[gi]),
                .last_tap   (ltap[gi])
            );
        end
    endgenerate

    always_comb
    begin
        rd_or   = '0;
        last_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_or   = rd_or | rtap[i];
            last_or = last_or | ltap[i];
        end
    end

    always_comb
    begin
        rsp_next.status     = status;
        rsp_next.length     = ial_pkg::LEN_FIELD_W'(len_next);
        rsp_next.last_value = last_or;
        if (status == ial_pkg::ST_BAD_INDEX)
            rsp_next.read_value = '1;
        else if (req.action == ial_pkg::ACT_READ)
            rsp_next.read_value = rd_or;
        else
            rsp_next.read_value = '0;
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (accept)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(CAPACITY))
        else $error("list length above capacity");

    a_full_append: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.action == ial_pkg::ACT_APPEND && full)
        |=> (rsp.status == ial_pkg::ST_FULL && $stable(len_reg)))
        else $error("append on full list not refused");

    a_bad_index_value: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ial_pkg::ST_BAD_INDEX) |-> (rsp.read_value == '1))
        else $error("bad index without -1 read value");

    a_len_matches: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.length == ial_pkg::LEN_FIELD_W'(len_reg)))
        else $error("response length differs from list length");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && len_reg == '0) |-> (rsp.last_value == '0))
        else $error("empty list with nonzero last value");

endmodule
